/* rtl/core/pdc_pkg.sv */
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants of the clamped PD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

   localparam int PDC_QUEUE_DEPTH = 2;

   localparam int ERR_W   = 32;
   localparam int DIFF_W  = 33;
   localparam int GAIN_W  = 24;
   localparam int STEP_W  = 24;
   localparam int LIMIT_W = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   // gain x error difference, 24 x 33 bits
   localparam int PROD_W  = GAIN_W + DIFF_W;
   // magnitude of the derivative product
   localparam int MAG_W   = PROD_W - 1;
   // truncated proportional term
   localparam int PROP_W  = PROD_W - 16;
   // -P - D, wide enough that it never wraps
   localparam int SUM_W   = MAG_W + 2;

   // divider retires two quotient bits per cycle
   localparam int DIV_STEPS = MAG_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_LOW  = 2'd3;

   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_HIGH = 2'd1;
   localparam logic [1:0] CLAMP_LOW  = 2'd2;

   typedef struct packed {
      logic [ERR_W-1:0]  error;
      logic [DIFF_W-1:0] diff;
      logic [STEP_W-1:0] step;
      logic              zero;
   } pdc_entry_type;

   typedef struct packed {
      logic [1:0]        clamp;
      logic              zero;
   } pdc_flags_type;

endpackage

`default_nettype wire

/* rtl/core/pdc_front.sv */
// ----------------------------------------------------------------------------
// pdc_front
// Takes request items, forms the error difference against the previous
// sample, flags a zero time step and pushes the item into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [pdc_pkg::ERR_W-1:0]    req_error_sample,
   input  wire logic [pdc_pkg::STEP_W-1:0]   req_step_time,
   input  wire logic                         q_full,
   output logic                              q_push,
   output pdc_pkg::pdc_entry_type            q_entry
);
   import pdc_pkg::*;

   logic [ERR_W-1:0] last_error_ff;
   logic [ERR_W-1:0] last_error_in;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.error = req_error_sample;
      q_entry.diff  = {req_error_sample[ERR_W-1], req_error_sample}
                    - {last_error_ff[ERR_W-1], last_error_ff};
      q_entry.step  = req_step_time;
      q_entry.zero  = (req_step_time == '0);
   end

   assign last_error_in = q_push ? req_error_sample : last_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
      end else begin
         last_error_ff <= last_error_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pdc_queue.sv */
// ----------------------------------------------------------------------------
// pdc_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_queue #(
   parameter int DEPTH = pdc_pkg::PDC_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire pdc_pkg::pdc_entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output logic                    pop_valid,
   output pdc_pkg::pdc_entry_type  pop_entry
);
   import pdc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pdc_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pdc_back.sv */
// ----------------------------------------------------------------------------
// pdc_back
// Control registers and the compute sequencer: shared multiplier, radix-4
// restoring divider for the derivative term, sum, clamp and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [pdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pdc_pkg::CSR_W-1:0]     csr_data,
   input  wire logic                          q_valid,
   input  wire pdc_pkg::pdc_entry_type        q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pdc_pkg::LIMIT_W-1:0]        rsp_drive,
   output pdc_pkg::pdc_flags_type             rsp_flags
);
   import pdc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MULP  = 3'd1;
   localparam logic [2:0] ST_MULD  = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   // control registers
   logic signed [GAIN_W-1:0]  gain_prop_ff, gain_deriv_ff;
   logic signed [LIMIT_W-1:0] limit_high_ff, limit_low_ff;

   logic [2:0]                state_ff, state_in;
   pdc_entry_type             ent_ff, ent_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROP_W-1:0]  prop_ff, prop_in;
   logic                      neg_ff, neg_in;
   logic [MAG_W-1:0]          quo_ff, quo_in;
   logic [STEP_W-1:0]         rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]        drive_ff, drive_in;
   pdc_flags_type             flags_ff, flags_in;

   logic signed [GAIN_W-1:0]  mul_a;
   logic signed [DIFF_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  prop_bias;
   logic [PROD_W-1:0]         prod_abs;
   logic [STEP_W:0]           r1, r2;
   logic [STEP_W+1:0]         t1, t2;
   logic [STEP_W-1:0]         rem1;
   logic                      b1, b2;
   logic signed [SUM_W-1:0]   deriv;
   logic signed [SUM_W-1:0]   lim_hi_x, lim_lo_x;
   logic                      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= '0;
         gain_deriv_ff <= '0;
         limit_high_ff <= {1'b0, {(LIMIT_W-1){1'b1}}};
         limit_low_ff  <= {1'b1, {(LIMIT_W-1){1'b0}}};
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN_PROP:  gain_prop_ff  <= csr_data[GAIN_W-1:0];
            CSR_GAIN_DERIV: gain_deriv_ff <= csr_data[GAIN_W-1:0];
            CSR_LIMIT_HIGH: limit_high_ff <= csr_data[LIMIT_W-1:0];
            CSR_LIMIT_LOW:  limit_low_ff  <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   // one shared multiplier: Kp*e first, then Kd*diff
   always_comb begin
      if (state_ff == ST_MULP) begin
         mul_a = gain_prop_ff;
         mul_b = $signed({ent_ff.error[ERR_W-1], ent_ff.error});
      end else begin
         mul_a = gain_deriv_ff;
         mul_b = $signed(ent_ff.diff);
      end
   end

   // truncate toward zero on the divide by 2^16
   assign prop_bias = prod_ff + $signed({{(PROD_W-16){1'b0}}, {16{prod_ff[PROD_W-1]}}});
   assign prod_abs  = prod_ff[PROD_W-1] ? (~prod_ff + 1'b1) : prod_ff;

   // two restoring steps per cycle
   always_comb begin
      r1   = {rem_ff, quo_ff[MAG_W-1]};
      t1   = {1'b0, r1} - {2'b0, ent_ff.step};
      b1   = !t1[STEP_W+1];
      rem1 = b1 ? t1[STEP_W-1:0] : r1[STEP_W-1:0];
      r2   = {rem1, quo_ff[MAG_W-2]};
      t2   = {1'b0, r2} - {2'b0, ent_ff.step};
      b2   = !t2[STEP_W+1];
   end

   always_comb begin
      if (ent_ff.zero) begin
         deriv = '0;
      end else if (neg_ff) begin
         deriv = -$signed({2'b0, quo_ff});
      end else begin
         deriv = $signed({2'b0, quo_ff});
      end
   end

   assign lim_hi_x = SUM_W'(limit_high_ff);
   assign lim_lo_x = SUM_W'(limit_low_ff);

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      prod_in      = prod_ff;
      prop_in      = prop_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      drive_in     = drive_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               ent_in   = q_entry;
               state_in = ST_MULP;
            end
         end
         ST_MULP: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            prop_in  = prop_bias[PROD_W-1:16];
            prod_in  = mul_a * mul_b;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            neg_in   = prod_ff[PROD_W-1];
            quo_in   = prod_abs[MAG_W-1:0];
            rem_in   = '0;
            cnt_in   = DIV_CNT_W'(DIV_STEPS - 1);
            state_in = ent_ff.zero ? ST_SUM : ST_DIV;
         end
         ST_DIV: begin
            quo_in = {quo_ff[MAG_W-3:0], b1, b2};
            rem_in = b2 ? t2[STEP_W-1:0] : r2[STEP_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = -SUM_W'(prop_ff) - deriv;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               flags_in.zero = ent_ff.zero;
               if (sum_ff > lim_hi_x) begin
                  drive_in       = limit_high_ff;
                  flags_in.clamp = CLAMP_HIGH;
               end else if (sum_ff < lim_lo_x) begin
                  drive_in       = limit_low_ff;
                  flags_in.clamp = CLAMP_LOW;
               end else begin
                  drive_in       = sum_ff[LIMIT_W-1:0];
                  flags_in.clamp = CLAMP_NONE;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      prod_ff  <= prod_in;
      prop_ff  <= prop_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      sum_ff   <= sum_in;
      drive_ff <= drive_in;
      flags_ff <= flags_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;
   assign rsp_flags = flags_ff;

endmodule

`default_nettype wire

/* rtl/core/pd_controller_clamped.sv */
// ----------------------------------------------------------------------------
// pd_controller_clamped
// Fixed-point PD controller, u = -Kp*e - Kd*(e - e_prev)/dt, clamped to limits.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    error_sample Q16.16, step_time Q8.16
//   rsp      out  rsp_valid/rsp_stall    drive Q16.16, clamp_state, zero_step
//   csr      in   csr_write              csr_index, csr_data
//
// Items compute one at a time: pop, two passes through the shared multiplier,
// setup, the divider steps (two quotient bits each over 56 bits), sum, clamp.
// A zero step_time skips the divider.
// Reset loads the register defaults, clears the previous error and empties
// the queue. The queue holds QUEUE_DEPTH items; req_stall rises when it is
// full. A stalled result holds in its register while the next item computes.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_controller_clamped #(
   parameter int QUEUE_DEPTH = pdc_pkg::PDC_QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pdc_pkg::ERR_W-1:0]     req_error_sample,
   input  wire logic [pdc_pkg::STEP_W-1:0]    req_step_time,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pdc_pkg::LIMIT_W-1:0]        rsp_drive,
   output logic [1:0]                         rsp_clamp_state,
   output logic                               rsp_zero_step,
   input  wire logic                          csr_write,
   input  wire logic [pdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pdc_pkg::CSR_W-1:0]     csr_data
);
   import pdc_pkg::*;

   logic          q_full, q_push, q_pop, q_valid;
   pdc_entry_type push_entry, pop_entry;
   pdc_flags_type flags;

   pdc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_error_sample (req_error_sample),
      .req_step_time    (req_step_time),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   pdc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   pdc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_drive (rsp_drive),
      .rsp_flags (flags)
   );

   assign rsp_clamp_state = flags.clamp;
   assign rsp_zero_step   = flags.zero;

endmodule

`default_nettype wire

/* rtl/core/pdc_checker.sv */
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks of the clamped PD controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [pdc_pkg::LIMIT_W-1:0] rsp_drive,
   input wire logic [1:0]                rsp_clamp_state,
   input wire logic                      rsp_zero_step
);
   import pdc_pkg::*;

   // items taken but not yet answered
   logic [7:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_clamp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_clamp_state == CLAMP_NONE || rsp_clamp_state == CLAMP_HIGH
                     || rsp_clamp_state == CLAMP_LOW))
      else $error("undefined clamp code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_clamp_state) && $stable(rsp_zero_step))
      else $error("stalled result changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without an outstanding item");

endmodule

bind pd_controller_clamped pdc_checker u_pdc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_drive       (rsp_drive),
   .rsp_clamp_state (rsp_clamp_state),
   .rsp_zero_step   (rsp_zero_step)
);

`default_nettype wire
